// ===== rtl/core/tes_pkg.sv =====
package tes_pkg;

	localparam int unsigned TYPE_W = 16;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned OCC_W  = 8;
	localparam int unsigned CFG_W  = 16;

	// Header bytes in front of every record body
	localparam logic [LEN_W-1:0] HDR_BYTES = 16'd4;

	// Configuration register indexes
	localparam logic REG_WANTED_TYPE       = 1'b0;
	localparam logic REG_WANTED_OCCURRENCE = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_FOUND     = 2'd0;
	localparam logic [1:0] STATUS_ABSENT    = 2'd1;
	localparam logic [1:0] STATUS_MALFORMED = 2'd2;

	typedef struct packed {
		logic [7:0] region_byte;
		logic       region_last;
	} in_t;

	typedef struct packed {
		logic [1:0]       search_status;
		logic [LEN_W-1:0] match_offset;
		logic [LEN_W-1:0] match_length;
	} out_t;

endpackage

// ===== rtl/core/tlv_extension_search.sv =====
// The result item is registered: out_valid rises in the cycle after the final region byte is taken.
// Throughput: one region byte per cycle, with no gap between regions.
// Input stalls only while a finished result waits in the output register and
// the sink holds out_ready low; the walk state is a single set of registers.
// Reset (arst_n low, asynchronous) clears the walk, both config registers and
// the output valid flag.
module tlv_extension_search #(
	parameter int unsigned OFFSET_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tes_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tes_pkg::out_t                out_data,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [tes_pkg::CFG_W-1:0]    cfg_wdata
);

	typedef enum logic [2:0] {
		PH_TYPE_HI = 3'd0,
		PH_TYPE_LO = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_BODY    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		OC_SEARCHING = 2'd0,
		OC_FOUND     = 2'd1,
		OC_BAD       = 2'd2
	} outcome_t;

	localparam int unsigned OCC_CNT_W = tes_pkg::OCC_W + 1;
	localparam logic [OCC_CNT_W-1:0] OCC_SAT = {1'b1, {tes_pkg::OCC_W{1'b0}}};

	// Configuration registers
	logic [tes_pkg::TYPE_W-1:0] wanted_type_q;
	logic [tes_pkg::OCC_W-1:0]  wanted_occ_q;

	// Walk state
	logic [OFFSET_BITS-1:0]     pos_q,       pos_d;
	phase_t                     phase_q,     phase_d;
	logic [tes_pkg::TYPE_W-1:0] rec_type_q,  rec_type_d;
	logic [7:0]                 len_hi_q,    len_hi_d;
	logic [tes_pkg::LEN_W-1:0]  body_rem_q,  body_rem_d;
	logic [OCC_CNT_W-1:0]       occ_cnt_q,   occ_cnt_d;
	logic [OFFSET_BITS-1:0]     cand_off_q,  cand_off_d;
	logic [tes_pkg::LEN_W-1:0]  cand_len_q,  cand_len_d;
	outcome_t                   outcome_q,   outcome_d;

	// Output register
	logic                       out_valid_q;
	tes_pkg::out_t              out_data_q;
	tes_pkg::out_t              result;
	logic [tes_pkg::LEN_W-1:0]  off16;

	logic                       in_acc;
	logic [tes_pkg::LEN_W-1:0]  cur_len;
	logic                       finish;

	// Take a byte whenever the output slot is free or being drained this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign cur_len = {len_hi_q, in_data.region_byte};

	// match_offset carries the low 16 bits of the stored start offset
	generate
		if (OFFSET_BITS >= tes_pkg::LEN_W) begin : g_off_wide
			assign off16 = cand_off_q[tes_pkg::LEN_W-1:0];
		end else begin : g_off_narrow
			assign off16 = {{(tes_pkg::LEN_W - OFFSET_BITS){1'b0}}, cand_off_q};
		end
	endgenerate

	// Advance the walk by one byte
	always_comb begin
		pos_d      = pos_q;
		phase_d    = phase_q;
		rec_type_d = rec_type_q;
		len_hi_d   = len_hi_q;
		body_rem_d = body_rem_q;
		occ_cnt_d  = occ_cnt_q;
		cand_off_d = cand_off_q;
		cand_len_d = cand_len_q;
		outcome_d  = outcome_q;
		finish     = 1'b0;

		if (outcome_q == OC_SEARCHING) begin
			case (phase_q)
				PH_TYPE_HI: begin
					cand_off_d = pos_q;
					rec_type_d = {in_data.region_byte, 8'd0};
					phase_d    = PH_TYPE_LO;
				end
				PH_TYPE_LO: begin
					rec_type_d = {rec_type_q[15:8], in_data.region_byte};
					phase_d    = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_hi_d = in_data.region_byte;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (cur_len < tes_pkg::HDR_BYTES) begin
						// Short length: stop the walk, phase stays in the header
						outcome_d = OC_BAD;
					end else begin
						cand_len_d = cur_len;
						body_rem_d = cur_len - tes_pkg::HDR_BYTES;
						if (cur_len == tes_pkg::HDR_BYTES) begin
							finish = 1'b1;
						end else begin
							phase_d = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					body_rem_d = body_rem_q - 1'b1;
					if (body_rem_q == 16'd1) begin
						finish = 1'b1;
					end
				end
				default: begin
					phase_d = PH_TYPE_HI;
				end
			endcase

			// Whole record arrived: count it or declare the match
			if (finish) begin
				phase_d = PH_TYPE_HI;
				if (rec_type_d == wanted_type_q) begin
					if (occ_cnt_q == {1'b0, wanted_occ_q}) begin
						outcome_d = OC_FOUND;
					end else if (occ_cnt_q != OCC_SAT) begin
						occ_cnt_d = occ_cnt_q + 1'b1;
					end
				end
			end
		end

		if (pos_q != {OFFSET_BITS{1'b1}}) begin
			pos_d = pos_q + 1'b1;
		end
	end

	// Result for the final byte, built from the state after that byte
	always_comb begin
		result = '0;
		if (outcome_d == OC_FOUND) begin
			result.search_status = tes_pkg::STATUS_FOUND;
			result.match_offset  = off16;
			result.match_length  = cand_len_d;
		end else if (outcome_d == OC_BAD || phase_d != PH_TYPE_HI) begin
			// Stopped on a bad length, or the region ended inside a record
			result.search_status = tes_pkg::STATUS_MALFORMED;
		end else begin
			result.search_status = tes_pkg::STATUS_ABSENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_type_q <= '0;
			wanted_occ_q  <= '0;
			pos_q         <= '0;
			phase_q       <= PH_TYPE_HI;
			rec_type_q    <= '0;
			len_hi_q      <= '0;
			body_rem_q    <= '0;
			occ_cnt_q     <= '0;
			cand_off_q    <= '0;
			cand_len_q    <= '0;
			outcome_q     <= OC_SEARCHING;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tes_pkg::REG_WANTED_TYPE: begin
						wanted_type_q <= cfg_wdata[tes_pkg::TYPE_W-1:0];
					end
					tes_pkg::REG_WANTED_OCCURRENCE: begin
						wanted_occ_q <= cfg_wdata[tes_pkg::OCC_W-1:0];
					end
					default: begin
						wanted_type_q <= wanted_type_q;
					end
				endcase
			end

			// Drop the held result once the sink takes it
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc) begin
				if (in_data.region_last) begin
					// Final byte: hand out the result and clear the walk
					out_valid_q <= 1'b1;
					pos_q       <= '0;
					phase_q     <= PH_TYPE_HI;
					rec_type_q  <= '0;
					len_hi_q    <= '0;
					body_rem_q  <= '0;
					occ_cnt_q   <= '0;
					cand_off_q  <= '0;
					cand_len_q  <= '0;
					outcome_q   <= OC_SEARCHING;
				end else begin
					pos_q      <= pos_d;
					phase_q    <= phase_d;
					rec_type_q <= rec_type_d;
					len_hi_q   <= len_hi_d;
					body_rem_q <= body_rem_d;
					occ_cnt_q  <= occ_cnt_d;
					cand_off_q <= cand_off_d;
					cand_len_q <= cand_len_d;
					outcome_q  <= outcome_d;
				end
			end
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (in_acc && in_data.region_last) begin
			out_data_q <= result;
		end
	end

	// A found record always has a legal declared length
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.search_status == tes_pkg::STATUS_FOUND
		|-> out_data.match_length >= tes_pkg::HDR_BYTES)
		else $error("found result with length below header size");

	// Offset and length are zero unless a record was found
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.search_status != tes_pkg::STATUS_FOUND
		|-> out_data.match_offset == '0 && out_data.match_length == '0)
		else $error("non-found result carries offset or length");

	// Inside a body at least one byte is still owed
	a_body_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> body_rem_q != '0)
		else $error("body phase with no bytes remaining");

	// The occurrence counter never passes its saturation value
	a_occ_sat: assert property (@(posedge clk) disable iff (!arst_n)
		occ_cnt_q[tes_pkg::OCC_W] |-> occ_cnt_q[tes_pkg::OCC_W-1:0] == '0)
		else $error("occurrence counter beyond saturation");

endmodule

// ===== tb/tlv_extension_search_tb.sv =====
module tlv_extension_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TYPE_W         = tes_pkg::TYPE_W;
	localparam int unsigned LEN_W          = tes_pkg::LEN_W;
	localparam int unsigned OCC_W          = tes_pkg::OCC_W;
	localparam int unsigned CFG_W          = tes_pkg::CFG_W;
	localparam int unsigned OFFSET_BITS    = 16;
	localparam int unsigned STALL_PCT      = 37;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	// Where the walk stands inside the current record
	typedef enum logic [2:0] {TYPE_HI, TYPE_LO, LEN_HI, LEN_LO, IN_BODY} hdr_step_e;
	// How far the search got in the current region
	typedef enum logic [1:0] {WALKING, MATCHED, BROKEN} walk_e;
	typedef logic [7:0] byte_q_t[$];

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	tes_pkg::in_t     in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	tes_pkg::out_t    out_data;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = tes_pkg::REG_WANTED_TYPE;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// Random gaps on both sides; cleared for gap-free stretches
	logic        gaps_on      = 1'b0;
	int unsigned failures     = 0;
	int unsigned quiet_cycles = 0;

	// Search results still owed by the block, oldest first
	tes_pkg::out_t search_results_due[$];

	// Shadow copy of the registers and of the walk
	logic [TYPE_W-1:0]      sel_type       = '0;
	logic [OCC_W-1:0]       sel_occurrence = '0;
	logic [OFFSET_BITS-1:0] cur_pos        = '0;
	hdr_step_e              hdr_step       = TYPE_HI;
	logic [TYPE_W-1:0]      cur_type       = '0;
	logic [7:0]             cur_len_hi     = '0;
	logic [LEN_W-1:0]       body_left      = '0;
	int unsigned            type_hits      = 0;
	logic [OFFSET_BITS-1:0] rec_start      = '0;
	logic [LEN_W-1:0]       rec_len        = '0;
	walk_e                  walk           = WALKING;

	tlv_extension_search #(
		.OFFSET_BITS(OFFSET_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Search predictor
	// ---------------------------------------------------------------

	// Close a complete record: bump the type count or latch the match
	function automatic void close_record();
		hdr_step = TYPE_HI;
		if (cur_type == sel_type) begin
			if (type_hits == sel_occurrence)
				walk = MATCHED;
			else if (type_hits < 256)
				type_hits++;
		end
	endfunction

	// Advance the shadow walk by one accepted byte; queue the result on the last one
	function automatic void predict_search(input logic [7:0] b, input logic last);
		logic [LEN_W-1:0] len;
		if (walk == WALKING) begin
			case (hdr_step)
			TYPE_HI: begin
				rec_start = cur_pos;
				cur_type  = {b, 8'h00};
				hdr_step  = TYPE_LO;
			end
			TYPE_LO: begin
				cur_type[7:0] = b;
				hdr_step      = LEN_HI;
			end
			LEN_HI: begin
				cur_len_hi = b;
				hdr_step   = LEN_LO;
			end
			LEN_LO: begin
				len = {cur_len_hi, b};
				if (len < tes_pkg::HDR_BYTES) begin
					// length too short to hold its own header
					walk = BROKEN;
				end else begin
					rec_len   = len;
					body_left = len - tes_pkg::HDR_BYTES;
					if (body_left == 0)
						close_record();
					else
						hdr_step = IN_BODY;
				end
			end
			default: begin
				if (body_left != 0)
					body_left--;
				if (body_left == 0)
					close_record();
			end
			endcase
		end
		// position saturates on very long regions
		if (cur_pos != POS_MAX)
			cur_pos++;
		if (last) begin
			if (walk == MATCHED)
				search_results_due.push_back('{search_status: tes_pkg::STATUS_FOUND,
					match_offset: rec_start[LEN_W-1:0], match_length: rec_len});
			else if (walk == BROKEN || hdr_step != TYPE_HI)
				search_results_due.push_back('{search_status: tes_pkg::STATUS_MALFORMED,
					match_offset: '0, match_length: '0});
			else
				search_results_due.push_back('{search_status: tes_pkg::STATUS_ABSENT,
					match_offset: '0, match_length: '0});
			// start over for the next region; registers stay
			cur_pos    = '0;
			hdr_step   = TYPE_HI;
			cur_type   = '0;
			cur_len_hi = '0;
			body_left  = '0;
			type_hits  = 0;
			rec_start  = '0;
			rec_len    = '0;
			walk       = WALKING;
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Offer one region byte; hold valid and payload until taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (gaps_on && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{region_byte: b, region_last: last};
		do @(posedge clk); while (!in_ready);
		predict_search(b, last);
	endtask

	task automatic send_region(ref byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	// Drop valid and wait until every owed result is out
	task automatic settle_block();
		in_valid <= 1'b0;
		while (search_results_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Registers are only written between regions with the block drained
	task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tes_pkg::REG_WANTED_TYPE)
			sel_type = value[TYPE_W-1:0];
		else
			sel_occurrence = value[OCC_W-1:0];
	endtask

	task automatic set_search(input logic [TYPE_W-1:0] typ, input logic [OCC_W-1:0] occ);
		write_register(tes_pkg::REG_WANTED_TYPE, typ);
		write_register(tes_pkg::REG_WANTED_OCCURRENCE, CFG_W'(occ));
	endtask

	// Append a record header with the given declared length and body_n random bytes
	function automatic void add_record(ref byte_q_t q, input logic [TYPE_W-1:0] typ,
			input logic [LEN_W-1:0] len, input int unsigned body_n);
		q.push_back(typ[15:8]);
		q.push_back(typ[7:0]);
		q.push_back(len[15:8]);
		q.push_back(len[7:0]);
		repeat (body_n)
			q.push_back(8'($urandom_range(255)));
	endfunction

	// Mostly well-formed regions around the wanted type, some broken, some noise
	function automatic void build_random_region(ref byte_q_t q);
		int unsigned kind = $urandom_range(99);
		int unsigned nrec = $urandom_range(5, 1);
		int unsigned roll;
		int unsigned n;
		logic [TYPE_W-1:0] typ;
		q.delete();
		if (kind < 12) begin
			repeat ($urandom_range(16, 1))
				q.push_back(8'($urandom_range(255)));
			return;
		end
		for (int i = 0; i < nrec; i++) begin
			roll = $urandom_range(99);
			if (roll < 55)
				typ = sel_type;
			else if (roll < 75)
				typ = sel_type ^ (16'h1 << $urandom_range(15));
			else
				typ = TYPE_W'($urandom_range(16'hFFFF));
			roll = $urandom_range(99);
			if (roll < 6) begin
				// short length: walk stops, the rest is ignored
				add_record(q, typ, LEN_W'($urandom_range(3)), $urandom_range(3));
				break;
			end else if (roll < 12) begin
				// declared length overruns the region
				add_record(q, typ, LEN_W'($urandom_range(16'hFFFF, 16'h0100)),
					$urandom_range(6));
				break;
			end
			n = $urandom_range(8);
			add_record(q, typ, tes_pkg::HDR_BYTES + LEN_W'(n), n);
		end
		if (kind < 24 && q.size() > 1) begin
			// cut the region short
			repeat ($urandom_range(q.size() - 1, 1))
				void'(q.pop_back());
		end else if (kind < 32) begin
			repeat ($urandom_range(4, 1))
				q.push_back(8'($urandom_range(255)));
		end
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// A lone record at the bottom of the type range, a match at the top behind other records
	task automatic test_single_records();
		byte_q_t q;
		set_search(16'h0000, 8'd0);
		q.delete();
		add_record(q, 16'h0000, 16'd4, 0);
		send_region(q);
		set_search(16'hFFFF, 8'd0);
		q.delete();
		add_record(q, 16'h1234, 16'd6, 2);
		add_record(q, 16'hFFFF, 16'd5, 1);
		add_record(q, 16'hFFFF, 16'd9, 5);
		send_region(q);
	endtask

	// Pick a later occurrence among interleaved types
	task automatic test_occurrences();
		byte_q_t q;
		set_search(16'h0101, 8'd2);
		q.delete();
		add_record(q, 16'h0A0A, 16'd4, 0);
		add_record(q, 16'h0101, 16'd5, 1);
		add_record(q, 16'h0101, 16'd4, 0);
		add_record(q, 16'h0A0A, 16'd7, 3);
		add_record(q, 16'h0101, 16'd8, 4);
		add_record(q, 16'h0101, 16'd4, 0);
		send_region(q);
	endtask

	// No record of the wanted type, near misses, too few occurrences
	task automatic test_absent();
		byte_q_t q;
		set_search(16'h0202, 8'd0);
		q.delete();
		add_record(q, 16'h0203, 16'd4, 0);
		add_record(q, 16'h0302, 16'd6, 2);
		add_record(q, 16'h8202, 16'd4, 0);
		send_region(q);
		set_search(16'h0202, 8'd2);
		q.delete();
		add_record(q, 16'h0202, 16'd4, 0);
		add_record(q, 16'h0202, 16'd5, 1);
		send_region(q);
	endtask

	// Declared lengths 0..3 stop the walk; a match before one still stands
	task automatic test_short_length();
		byte_q_t q;
		set_search(16'h00C3, 8'd0);
		for (int len = 0; len < 4; len++) begin
			q.delete();
			add_record(q, 16'h0011, 16'd4, 0);
			add_record(q, 16'h00C3, LEN_W'(len), 3);
			send_region(q);
		end
		q.delete();
		add_record(q, 16'h00C3, 16'd6, 2);
		add_record(q, 16'h0011, 16'd2, 2);
		send_region(q);
	endtask

	// Regions ending inside a header or a body
	task automatic test_truncation();
		byte_q_t q;
		set_search(16'h00C3, 8'd0);
		for (int cut = 1; cut < 4; cut++) begin
			q.delete();
			add_record(q, 16'h00C3, 16'd4, 0);
			repeat (4 - cut)
				void'(q.pop_back());
			send_region(q);
		end
		// wanted record missing its last body bytes
		q.delete();
		add_record(q, 16'h00C3, 16'd8, 2);
		send_region(q);
		// largest declared length, far beyond the region
		q.delete();
		add_record(q, 16'h7777, 16'hFFFF, 5);
		send_region(q);
		// match already complete, then a cut record
		q.delete();
		add_record(q, 16'h00C3, 16'd5, 1);
		add_record(q, 16'h7777, 16'd12, 3);
		send_region(q);
	endtask

	// Random regions with occasional retuning of the search between them
	task automatic test_random();
		byte_q_t q;
		int unsigned sent = 0;
		int unsigned regions = 0;
		while (sent < 270 || regions < 12) begin
			// open with a gap-free stretch
			gaps_on = (regions >= 8);
			if ($urandom_range(7) == 0) begin
				if ($urandom_range(3) == 0)
					write_register(tes_pkg::REG_WANTED_TYPE,
						CFG_W'($urandom_range(16'hFFFF)));
				else
					write_register(tes_pkg::REG_WANTED_TYPE, CFG_W'($urandom_range(3)));
				if ($urandom_range(9) == 0)
					write_register(tes_pkg::REG_WANTED_OCCURRENCE, CFG_W'(255));
				else
					write_register(tes_pkg::REG_WANTED_OCCURRENCE,
						CFG_W'($urandom_range(3)));
			end
			build_random_region(q);
			send_region(q);
			sent += q.size();
			regions++;
		end
	endtask

	// ---------------------------------------------------------------
	// Result checking and the output side
	// ---------------------------------------------------------------

	function automatic void check_field(input string name, input logic [LEN_W-1:0] want,
			input logic [LEN_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// Compare every taken result with the oldest owed one; stall the sink at random
	always @(posedge clk) begin : check_results
		tes_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (search_results_due.size() == 0) begin
				$error("result with none owed: status %0d offset %0d length %0d",
					out_data.search_status, out_data.match_offset, out_data.match_length);
				failures++;
			end else begin
				want = search_results_due.pop_front();
				check_field("search_status", LEN_W'(want.search_status),
					LEN_W'(out_data.search_status));
				check_field("match_offset", want.match_offset, out_data.match_offset);
				check_field("match_length", want.match_length, out_data.match_length);
			end
		end
		out_ready <= !(gaps_on && $urandom_range(99) < STALL_PCT);
	end

	// Give up when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		gaps_on = 1'b1;
		test_single_records();
		test_occurrences();
		test_absent();
		test_short_length();
		test_truncation();
		test_random();
		settle_block();
		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
